[rtl/mbp_pkg.sv]
// Shared constants, codes and control/status types of the MIDI byte stream parser.
`default_nettype none

package mbp_pkg;

    // SysEx store depth; one slot is always kept for the end byte.
    localparam int SYSEX_DEPTH = 64;
    localparam int C_AW        = $clog2(SYSEX_DEPTH);
    localparam logic [C_AW-1:0] C_CNT_MAX = C_AW'(SYSEX_DEPTH - 1);

    localparam logic [7:0] C_RT_MIN    = 8'hF8;  // real-time bytes and up
    localparam logic [7:0] C_SX_START  = 8'hF0;  // also first system byte
    localparam logic [7:0] C_SX_END    = 8'hF7;
    localparam logic [2:0] C_ONE_TOP   = 3'b110; // 0xC0..0xDF: one data byte

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_RT = 2'd0;
    localparam t_kind KIND_CH = 2'd1;
    localparam t_kind KIND_SX = 2'd2;

    // Output byte source
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_BYTE = 2'd0;
    localparam t_sel SEL_RS   = 2'd1;
    localparam t_sel SEL_FD   = 2'd2;
    localparam t_sel SEL_SX   = 2'd3;

    // Class of the captured byte
    typedef logic [2:0] t_cls;
    localparam t_cls CLS_NONE  = 3'd0;
    localparam t_cls CLS_RT    = 3'd1;
    localparam t_cls CLS_SXEND = 3'd2;
    localparam t_cls CLS_CH1   = 3'd3;
    localparam t_cls CLS_CH2   = 3'd4;

    typedef struct packed {
        logic  capture;
        logic  update;
        logic  idx_clr;
        logic  load;
        t_sel  sel;
        t_kind kind;
        logic  first;
        logic  last;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic out_free;
        logic sx_last;
    } t_sts;

endpackage

`default_nettype wire

[rtl/mbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/mbp_dp.sv]
// Datapath: parser state registers, SysEx store and output register.
`default_nettype none

module mbp_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_rx_byte,
    input  wire mbp_pkg::t_cmd i_cmd,
    output mbp_pkg::t_sts      o_sts,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic [1:0]         o_msg_kind,
    output logic               o_first_of_msg,
    output logic               o_last_of_msg,
    output logic               o_sysex_truncated
);
    import mbp_pkg::*;

    logic [7:0]      r_byte;
    logic [7:0]      r_rs, n_rs;
    logic            r_dc, n_dc;
    logic [6:0]      r_fd, n_fd;
    logic            r_insx, n_insx;
    logic [C_AW-1:0] r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    logic [C_AW-1:0] r_idx, n_idx;

    logic            w_is_rt, w_is_start, w_is_end, w_one, w_sx_last, w_sx_load;
    logic            w_we;
    logic [C_AW-1:0] w_waddr, w_raddr;
    logic [7:0]      w_rdata;
    t_cls            w_cls;
    logic [7:0]      w_obyte;

    assign w_is_rt    = (r_byte >= C_RT_MIN);
    assign w_is_start = (r_byte == C_SX_START);
    assign w_is_end   = (r_byte == C_SX_END);
    assign w_one      = (r_rs[7:5] == C_ONE_TOP);
    assign w_sx_last  = (r_idx == r_cnt);
    assign w_sx_load  = i_cmd.load && (i_cmd.sel == SEL_SX);

    always_comb begin
        priority if (w_is_rt)          w_cls = CLS_RT;
        else if (w_is_start)           w_cls = CLS_NONE;
        else if (r_insx)               w_cls = w_is_end ? CLS_SXEND : CLS_NONE;
        else if (r_byte[7])            w_cls = CLS_NONE;
        else if (r_rs == 8'h00)        w_cls = CLS_NONE;
        else if (w_one)                w_cls = CLS_CH1;
        else if (r_dc)                 w_cls = CLS_CH2;
        else                           w_cls = CLS_NONE;
    end

    assign o_sts.cls      = w_cls;
    assign o_sts.out_free = !o_out_valid || i_out_ready;
    assign o_sts.sx_last  = w_sx_last;

    // state update for the captured byte
    always_comb begin
        n_rs    = r_rs;
        n_dc    = r_dc;
        n_fd    = r_fd;
        n_insx  = r_insx;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        w_we    = 1'b0;
        w_waddr = r_cnt;
        if (i_cmd.update && !w_is_rt) begin
            priority if (w_is_start) begin
                n_insx  = 1'b1;
                n_ovf   = 1'b0;
                n_cnt   = C_AW'(1);
                w_we    = 1'b1;
                w_waddr = '0;
            end else if (r_insx) begin
                if (w_is_end) begin
                    n_insx = 1'b0;
                end else if (r_cnt < C_CNT_MAX) begin
                    w_we  = 1'b1;
                    n_cnt = r_cnt + C_AW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end else if (r_byte[7]) begin
                if (r_byte < C_SX_START) begin
                    n_rs = r_byte;
                    n_dc = 1'b0;
                end
            end else if ((r_rs != 8'h00) && !w_one) begin
                if (!r_dc) begin
                    n_fd = r_byte[6:0];
                    n_dc = 1'b1;
                end else begin
                    n_dc = 1'b0;
                end
            end
        end
    end

    // read index runs one ahead while bytes are being loaded
    always_comb begin
        n_idx   = r_idx;
        w_raddr = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (w_sx_load) begin
            n_idx = r_idx + C_AW'(1);
            if (!w_sx_last) begin
                w_raddr = r_idx + C_AW'(1);
            end
        end
    end

    mbp_ram #(
        .WIDTH(8),
        .DEPTH(SYSEX_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (i_cmd.sel)
            SEL_BYTE: w_obyte = r_byte;
            SEL_RS:   w_obyte = r_rs;
            SEL_FD:   w_obyte = {1'b0, r_fd};
            SEL_SX:   w_obyte = w_sx_last ? C_SX_END : w_rdata;
            default:  w_obyte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs        <= '0;
            r_dc        <= 1'b0;
            r_fd        <= '0;
            r_insx      <= 1'b0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_rs   <= n_rs;
            r_dc   <= n_dc;
            r_fd   <= n_fd;
            r_insx <= n_insx;
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
            if (i_cmd.load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.capture) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.load) begin
            o_out_byte        <= w_obyte;
            o_msg_kind        <= i_cmd.kind;
            o_first_of_msg    <= (i_cmd.sel == SEL_SX) ? (r_idx == '0) : i_cmd.first;
            o_last_of_msg     <= (i_cmd.sel == SEL_SX) ? w_sx_last : i_cmd.last;
            o_sysex_truncated <= (i_cmd.sel == SEL_SX) ? r_ovf : 1'b0;
        end
    end

endmodule

`default_nettype wire

[rtl/mbp_ctrl.sv]
// Controller: sequences capture, decode and per-byte emission of messages.
`default_nettype none

module mbp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mbp_pkg::t_sts i_sts,
    output mbp_pkg::t_cmd      o_cmd
);
    import mbp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_RT   = 4'd2;
    localparam logic [3:0] S_C2S  = 4'd3;  // status of a two-byte message
    localparam logic [3:0] S_C3S  = 4'd4;  // status of a three-byte message
    localparam logic [3:0] S_CFD  = 4'd5;
    localparam logic [3:0] S_CDB  = 4'd6;
    localparam logic [3:0] S_SXP  = 4'd7;  // RAM read priming
    localparam logic [3:0] S_SXE  = 4'd8;

    logic [3:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.update  = 1'b1;
                o_cmd.idx_clr = 1'b1;
                unique case (i_sts.cls)
                    CLS_RT:    n_state = S_RT;
                    CLS_SXEND: n_state = S_SXP;
                    CLS_CH1:   n_state = S_C2S;
                    CLS_CH2:   n_state = S_C3S;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_RT: begin
                if (i_sts.out_free) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.sel   = SEL_BYTE;
                    o_cmd.kind  = KIND_RT;
                    o_cmd.first = 1'b1;
                    o_cmd.last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_C2S, S_C3S: begin
                if (i_sts.out_free) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.sel   = SEL_RS;
                    o_cmd.kind  = KIND_CH;
                    o_cmd.first = 1'b1;
                    n_state     = (r_state == S_C2S) ? S_CDB : S_CFD;
                end
            end
            S_CFD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = SEL_FD;
                    o_cmd.kind = KIND_CH;
                    n_state    = S_CDB;
                end
            end
            S_CDB: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = SEL_BYTE;
                    o_cmd.kind = KIND_CH;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SXP: begin
                n_state = S_SXE;
            end
            S_SXE: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = SEL_SX;
                    o_cmd.kind = KIND_SX;
                    if (i_sts.sx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/midi_byte_stream_parser_core.sv]
// Top level of the MIDI byte stream parser: controller, datapath and checks.
//
// Usage
//   Input channel (i_in_valid / o_in_ready, payload i_rx_byte): one received
//   MIDI byte per transaction. Output channel (o_out_valid / i_out_ready):
//   one byte of a complete message per transaction, with its kind, first /
//   last markers and the SysEx truncation flag.
//   Real-time bytes (0xF8..0xFF) leave at once as one-byte messages, even in
//   the middle of a SysEx. Channel messages use running status and leave as
//   two or three transactions. A SysEx is kept in a SYSEX_DEPTH-entry RAM
//   and leaves as one burst when 0xF7 arrives; body bytes that do not fit
//   are dropped and the whole burst is marked truncated.
// Timing
//   A byte that yields no output passes through capture and decode. A byte
//   that completes a message then emits its output bytes in turn, after a
//   RAM priming state for a SysEx. While the receiver does not stall, the
//   rate is set by the single output register: one result byte per cycle,
//   read out of the store one entry per cycle.
//   The first result is registered after the capture and decode states,
//   for a SysEx burst after the RAM priming state as well.
// Reset / stall
//   Synchronous active-low reset clears running status, SysEx state and the
//   output valid; the store needs no clearing. When the receiver stalls, the
//   output register holds its transaction and emission pauses; the next
//   input byte is taken once the last result is in the output register.
`default_nettype none

module midi_byte_stream_parser_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_msg_kind,
    output logic            o_first_of_msg,
    output logic            o_last_of_msg,
    output logic            o_sysex_truncated
);
    import mbp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing: capture -> decode -> emit
    mbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // parser state, SysEx store and the output register
    mbp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_out_byte        (o_out_byte),
        .o_msg_kind        (o_msg_kind),
        .o_first_of_msg    (o_first_of_msg),
        .o_last_of_msg     (o_last_of_msg),
        .o_sysex_truncated (o_sysex_truncated)
    );

    // A SysEx burst opens with its start byte.
    a_sx_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_msg_kind == KIND_SX && o_first_of_msg)
            |-> (o_out_byte == C_SX_START))
        else $error("SysEx burst does not start with 0xF0");

    // A SysEx burst closes with its end byte.
    a_sx_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_msg_kind == KIND_SX && o_last_of_msg)
            |-> (o_out_byte == C_SX_END))
        else $error("SysEx burst does not end with 0xF7");

    // Real-time output is a single self-contained byte.
    a_rt_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_msg_kind == KIND_RT)
            |-> (o_first_of_msg && o_last_of_msg && o_out_byte >= C_RT_MIN))
        else $error("malformed real-time transaction");

    // Channel messages lead with a status byte; data bytes never carry bit 7.
    a_ch_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_msg_kind == KIND_CH)
            |-> (o_out_byte[7] == o_first_of_msg))
        else $error("channel message status/data position wrong");

endmodule

`default_nettype wire
